// File: hw/rtl/feedback_delay_dry_wet_mix_macros.svh
// Assertion macros for the feedback delay with dry/wet mix.
// Every macro samples on aclk and is switched off while aresetn is low.
`ifndef FEEDBACK_DELAY_DRY_WET_MIX_MACROS_SVH
`define FEEDBACK_DELAY_DRY_WET_MIX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fdm_pkg.sv
// Shared constants, payload types and arithmetic helpers for the feedback delay.
// Has no dependencies; the modules of the block and the testbench refer to it by scoped names.
package fdm_pkg;

    localparam int DELAY_DEPTH   = 131072;
    localparam int CHANNEL_COUNT = 2;

    localparam int ADDR_W    = $clog2(DELAY_DEPTH);
    localparam int CH_SEL_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int MEM_DEPTH = CHANNEL_COUNT * DELAY_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam int SAMPLE_W  = 24;
    localparam int CHANNEL_W = 1;
    localparam int GAIN_W    = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 42;
    localparam int SCALED_W  = PROD_W - FRAC_W;

    localparam logic [GAIN_W-1:0] UNITY_GAIN     = GAIN_W'(65536);
    localparam logic [CFG_W-1:0]  DELAY_RESET    = CFG_W'(48000);
    localparam logic [CFG_W-1:0]  MIX_RESET      = CFG_W'(32768);
    localparam logic [CFG_W-1:0]  FEEDBACK_RESET = CFG_W'(0);

    localparam logic signed [PROD_W-1:0]   ROUND_BIAS = PROD_W'(32768);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_SAMPLES = 2'd0,
        CFG_MIX_GAIN      = 2'd1,
        CFG_FEEDBACK_GAIN = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0]       channel_index;
        logic signed [SAMPLE_W-1:0] in_sample;
    } in_item_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0]       out_channel;
        logic signed [SAMPLE_W-1:0] out_sample;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] delay;
        logic [GAIN_W-1:0] mix_gain;
        logic [GAIN_W-1:0] dry_gain;
        logic [GAIN_W-1:0] feedback_gain;
    } cfg_t;

    typedef struct packed {
        logic              in_range;
        logic              unwritten;
        logic [MEM_AW-1:0] rd_addr;
        logic [MEM_AW-1:0] wr_addr;
    } addr_req_t;

    function automatic logic [ADDR_W-1:0] clamp_delay(input logic [CFG_W-1:0] value);
        logic [ADDR_W-1:0] result;
        if (value == '0) begin
            result = ADDR_W'(1);
        end else if (32'(value) > DELAY_DEPTH - 1) begin
            result = ADDR_W'(DELAY_DEPTH - 1);
        end else begin
            result = ADDR_W'(value);
        end
        return result;
    endfunction

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [CFG_W-1:0] value);
        logic [GAIN_W-1:0] result;
        if (32'(value) > 32'(UNITY_GAIN)) begin
            result = UNITY_GAIN;
        end else begin
            result = GAIN_W'(value);
        end
        return result;
    endfunction

    // Drops the Q16 fraction (the bias is already added) and saturates to a sample.
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] value
    );
        logic signed [SCALED_W-1:0] scaled;
        logic signed [SAMPLE_W-1:0] result;
        scaled = value[PROD_W-1:FRAC_W];
        if (scaled > SCALED_W'(SAMPLE_MAX)) begin
            result = SAMPLE_MAX;
        end else if (scaled < SCALED_W'(SAMPLE_MIN)) begin
            result = SAMPLE_MIN;
        end else begin
            result = scaled[SAMPLE_W-1:0];
        end
        return result;
    endfunction

endpackage

// File: hw/rtl/feedback_delay_dry_wet_mix.sv
// Feedback delay with dry/wet mix, one delay line per channel in a shared memory.
// Pipeline: an accepted transaction passes the read stage, the product stage and the output register.
// Throughput: one transaction per cycle while the output is not stalled; a transaction that reads the entry
// written by the transaction just before it (delay of one, same channel) is held off until that write is forwarded.
// Reset clears write positions and fill flags, so unwritten entries read as zero at once.
`include "feedback_delay_dry_wet_mix_macros.svh"

module feedback_delay_dry_wet_mix (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  fdm_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output fdm_pkg::out_item_t             m_data,
    input  logic                           cfg_wr_en,
    input  logic [fdm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdm_pkg::CFG_W-1:0]      cfg_wr_data
);

    fdm_pkg::cfg_t      cfg;
    fdm_pkg::addr_req_t req;

    logic advance, hazard, accept, wr_en;
    logic [fdm_pkg::SAMPLE_W-1:0] rd_data;

    logic                               r_valid_reg, r_valid_next;
    logic [fdm_pkg::CHANNEL_W-1:0]      r_channel_reg;
    logic signed [fdm_pkg::SAMPLE_W-1:0] r_sample_reg;
    logic                               r_in_range_reg;
    logic                               r_unwritten_reg;
    logic                               r_fwd_reg;
    logic [fdm_pkg::MEM_AW-1:0]         r_wr_addr_reg;
    logic signed [fdm_pkg::SAMPLE_W-1:0] fwd_data_reg;

    logic                               p_valid_reg, p_valid_next;
    logic [fdm_pkg::CHANNEL_W-1:0]      p_channel_reg;
    logic signed [fdm_pkg::SAMPLE_W-1:0] p_sample_reg;
    logic                               p_in_range_reg;
    logic [fdm_pkg::MEM_AW-1:0]         p_wr_addr_reg;
    logic signed [fdm_pkg::PROD_W-1:0]  p_fb_prod_reg;
    logic signed [fdm_pkg::PROD_W-1:0]  p_dry_prod_reg;
    logic signed [fdm_pkg::PROD_W-1:0]  p_wet_prod_reg;

    logic                               out_valid_reg, out_valid_next;
    fdm_pkg::out_item_t                 out_item_reg;

    logic signed [fdm_pkg::SAMPLE_W-1:0] delayed;
    logic signed [fdm_pkg::PROD_W-1:0]   fb_prod, dry_prod, wet_prod;
    logic signed [fdm_pkg::PROD_W-1:0]   fb_sum, mix_sum;
    logic signed [fdm_pkg::SAMPLE_W-1:0] fb_value, mix_value;

    fdm_cfg_regs u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    fdm_addr_gen u_addr_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .channel (s_data.channel_index),
        .delay   (cfg.delay),
        .req     (req)
    );

    fdm_delay_mem u_delay_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (p_wr_addr_reg),
        .wr_data (fb_value),
        .rd_en   (accept),
        .rd_addr (req.rd_addr),
        .rd_data (rd_data)
    );

    assign advance = !out_valid_reg || m_ready;
    assign hazard  = r_valid_reg && r_in_range_reg && req.in_range
                     && (req.rd_addr == r_wr_addr_reg);
    assign s_ready = advance && !hazard;
    assign accept  = s_valid && s_ready;
    assign wr_en   = advance && p_valid_reg && p_in_range_reg;

    assign delayed  = r_fwd_reg ? fwd_data_reg : (r_unwritten_reg ? '0 : rd_data);
    assign fb_prod  = delayed * $signed({1'b0, cfg.feedback_gain});
    assign wet_prod = delayed * $signed({1'b0, cfg.mix_gain});
    assign dry_prod = r_sample_reg * $signed({1'b0, cfg.dry_gain});

    assign fb_sum    = (fdm_pkg::PROD_W'(p_sample_reg) <<< fdm_pkg::FRAC_W)
                       + p_fb_prod_reg + fdm_pkg::ROUND_BIAS;
    assign mix_sum   = p_dry_prod_reg + p_wet_prod_reg + fdm_pkg::ROUND_BIAS;
    assign fb_value  = fdm_pkg::round_sat(fb_sum);
    assign mix_value = fdm_pkg::round_sat(mix_sum);

    always_comb begin
        r_valid_next   = r_valid_reg;
        p_valid_next   = p_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            r_valid_next   = accept;
            p_valid_next   = r_valid_reg;
            out_valid_next = p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            r_valid_reg   <= r_valid_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            r_channel_reg   <= s_data.channel_index;
            r_sample_reg    <= s_data.in_sample;
            r_in_range_reg  <= req.in_range;
            r_unwritten_reg <= req.unwritten;
            r_wr_addr_reg   <= req.wr_addr;
            r_fwd_reg       <= wr_en && (p_wr_addr_reg == req.rd_addr);
        end
        if (wr_en) begin
            fwd_data_reg <= fb_value;
        end
        if (advance) begin
            p_channel_reg  <= r_channel_reg;
            p_sample_reg   <= r_sample_reg;
            p_in_range_reg <= r_in_range_reg;
            p_wr_addr_reg  <= r_wr_addr_reg;
            p_fb_prod_reg  <= fb_prod;
            p_dry_prod_reg <= dry_prod;
            p_wet_prod_reg <= wet_prod;
            if (p_valid_reg) begin
                out_item_reg.out_channel <= p_channel_reg;
                out_item_reg.out_sample  <= p_in_range_reg ? mix_value : p_sample_reg;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    `FDM_ASSERT_SAME(a_no_pending_read, accept && r_valid_reg && r_in_range_reg && req.in_range, req.rd_addr != r_wr_addr_reg, "Read accepted for an entry whose write is still pending.")
    `FDM_ASSERT_SAME(a_fwd_entry_written, r_valid_reg && r_fwd_reg, !r_unwritten_reg, "Forwarded entry is marked as never written.")
    `FDM_ASSERT_NEXT(a_stage_holds, p_valid_reg && !advance, p_valid_reg && $stable(p_wr_addr_reg), "Product stage changed while the output was stalled.")
    `FDM_ASSERT_NEXT(a_write_has_result, wr_en, out_valid_reg, "Delay line written without a result being registered.")

endmodule

// File: hw/rtl/fdm_cfg_regs.sv
// Configuration registers of the feedback delay, stored already clamped.
// Depends on fdm_pkg for widths, register indexes and clamp functions.
module fdm_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [fdm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdm_pkg::CFG_W-1:0]      cfg_wr_data,
    output fdm_pkg::cfg_t                  cfg
);

    logic [fdm_pkg::ADDR_W-1:0] delay_reg, delay_next;
    logic [fdm_pkg::GAIN_W-1:0] mix_reg, mix_next;
    logic [fdm_pkg::GAIN_W-1:0] dry_reg, dry_next;
    logic [fdm_pkg::GAIN_W-1:0] fb_reg, fb_next;

    always_comb begin
        delay_next = delay_reg;
        mix_next   = mix_reg;
        dry_next   = dry_reg;
        fb_next    = fb_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                fdm_pkg::CFG_DELAY_SAMPLES: begin
                    delay_next = fdm_pkg::clamp_delay(cfg_wr_data);
                end
                fdm_pkg::CFG_MIX_GAIN: begin
                    mix_next = fdm_pkg::clamp_gain(cfg_wr_data);
                    dry_next = fdm_pkg::UNITY_GAIN - fdm_pkg::clamp_gain(cfg_wr_data);
                end
                fdm_pkg::CFG_FEEDBACK_GAIN: begin
                    fb_next = fdm_pkg::clamp_gain(cfg_wr_data);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= fdm_pkg::clamp_delay(fdm_pkg::DELAY_RESET);
            mix_reg   <= fdm_pkg::clamp_gain(fdm_pkg::MIX_RESET);
            dry_reg   <= fdm_pkg::UNITY_GAIN - fdm_pkg::clamp_gain(fdm_pkg::MIX_RESET);
            fb_reg    <= fdm_pkg::clamp_gain(fdm_pkg::FEEDBACK_RESET);
        end else begin
            delay_reg <= delay_next;
            mix_reg   <= mix_next;
            dry_reg   <= dry_next;
            fb_reg    <= fb_next;
        end
    end

    assign cfg.delay         = delay_reg;
    assign cfg.mix_gain      = mix_reg;
    assign cfg.dry_gain      = dry_reg;
    assign cfg.feedback_gain = fb_reg;

endmodule

// File: hw/rtl/fdm_addr_gen.sv
// Per-channel write positions and fill flags; forms the read and write addresses.
// Depends on fdm_pkg for the memory geometry and the address request type.
module fdm_addr_gen (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic [fdm_pkg::CHANNEL_W-1:0]  channel,
    input  logic [fdm_pkg::ADDR_W-1:0]     delay,
    output fdm_pkg::addr_req_t             req
);

    logic [fdm_pkg::ADDR_W-1:0]        wp_reg [fdm_pkg::CHANNEL_COUNT];
    logic [fdm_pkg::ADDR_W-1:0]        wp_next [fdm_pkg::CHANNEL_COUNT];
    logic [fdm_pkg::CHANNEL_COUNT-1:0] wrapped_reg, wrapped_next;

    logic [fdm_pkg::CH_SEL_W-1:0] sel;
    logic                         in_range;
    logic [fdm_pkg::ADDR_W-1:0]   wp;
    logic [fdm_pkg::ADDR_W-1:0]   rp;
    logic [fdm_pkg::MEM_AW-1:0]   base;

    assign sel      = fdm_pkg::CH_SEL_W'(channel);
    assign in_range = 32'(channel) < fdm_pkg::CHANNEL_COUNT;
    assign wp       = wp_reg[sel];
    assign rp       = (wp >= delay) ? wp - delay
                                    : wp + fdm_pkg::ADDR_W'(fdm_pkg::DELAY_DEPTH) - delay;
    assign base     = fdm_pkg::MEM_AW'(sel) * fdm_pkg::MEM_AW'(fdm_pkg::DELAY_DEPTH);

    assign req.in_range  = in_range;
    assign req.unwritten = !wrapped_reg[sel] && (rp >= wp);
    assign req.rd_addr   = base + fdm_pkg::MEM_AW'(rp);
    assign req.wr_addr   = base + fdm_pkg::MEM_AW'(wp);

    always_comb begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (accept && in_range) begin
            if (wp == fdm_pkg::ADDR_W'(fdm_pkg::DELAY_DEPTH - 1)) begin
                wp_next[sel]      = '0;
                wrapped_next[sel] = 1'b1;
            end else begin
                wp_next[sel] = wp + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '{default: '0};
            wrapped_reg <= '0;
        end else begin
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
        end
    end

endmodule

// File: hw/rtl/fdm_delay_mem.sv
// Delay line storage for all channels: one write port, one registered read port.
// A read and a write of the same entry in one cycle return the old contents.
module fdm_delay_mem (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [fdm_pkg::MEM_AW-1:0]    wr_addr,
    input  logic [fdm_pkg::SAMPLE_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [fdm_pkg::MEM_AW-1:0]    rd_addr,
    output logic [fdm_pkg::SAMPLE_W-1:0]  rd_data
);

    logic [fdm_pkg::SAMPLE_W-1:0] mem [fdm_pkg::MEM_DEPTH];
    logic [fdm_pkg::SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for feedback_delay_dry_wet_mix: directed and random
// sample streams under several register settings, checked against an in-bench echo model.
// Depends on fdm_pkg and on the feedback_delay_dry_wet_mix RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [fdm_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int SQUEEZE_CYCLES = 300;

    typedef enum logic [1:0] {
        DRAIN_STEADY,
        DRAIN_CHOPPY,
        DRAIN_SPARSE
    } drain_mode_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    fdm_pkg::in_item_t             s_data = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    fdm_pkg::out_item_t            m_data;
    logic                          cfg_wr_en = 1'b0;
    logic [fdm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [fdm_pkg::CFG_W-1:0]     cfg_wr_data = '0;

    logic [fdm_pkg::CFG_W-1:0] delay_reg = fdm_pkg::DELAY_RESET;
    logic [fdm_pkg::CFG_W-1:0] mix_reg = fdm_pkg::MIX_RESET;
    logic [fdm_pkg::CFG_W-1:0] feedback_reg = fdm_pkg::FEEDBACK_RESET;

    bit signed [fdm_pkg::SAMPLE_W-1:0] echo_line [fdm_pkg::CHANNEL_COUNT][fdm_pkg::DELAY_DEPTH];
    int unsigned                       echo_wr_pos [fdm_pkg::CHANNEL_COUNT];

    fdm_pkg::in_item_t  sample_feed_q[$];
    fdm_pkg::out_item_t predicted_mix_q[$];
    fdm_pkg::out_item_t oldest_mix;
    int                 mismatch_count = 0;
    int                 feed_burst = 1;
    int                 feed_gap = 0;
    bit                 squeeze_armed = 1'b0;
    int                 squeeze_left = 0;
    int                 drain_left = 0;
    drain_mode_t        drain_mode = DRAIN_STEADY;

    feedback_delay_dry_wet_mix dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic signed [fdm_pkg::SAMPLE_W-1:0] scale_clip(input longint acc);
        longint scaled;
        scaled = (acc + 64'sd32768) >>> fdm_pkg::FRAC_W;
        if (scaled > longint'(fdm_pkg::SAMPLE_MAX)) begin
            return fdm_pkg::SAMPLE_MAX;
        end else if (scaled < longint'(fdm_pkg::SAMPLE_MIN)) begin
            return fdm_pkg::SAMPLE_MIN;
        end
        return fdm_pkg::SAMPLE_W'(scaled);
    endfunction

    function automatic fdm_pkg::out_item_t predict_echo_mix(input fdm_pkg::in_item_t item);
        fdm_pkg::out_item_t res;
        longint             dry;
        longint             wet;
        longint             mix_w;
        longint             fb_w;
        int unsigned        ch;
        int unsigned        span;
        int unsigned        rd;
        int unsigned        wr;
        ch = item.channel_index;
        dry = longint'($signed(item.in_sample));
        res.out_channel = item.channel_index;
        res.out_sample = item.in_sample;
        if (ch < fdm_pkg::CHANNEL_COUNT) begin
            span = delay_reg;
            if (span < 1) begin
                span = 1;
            end
            if (span > fdm_pkg::DELAY_DEPTH - 1) begin
                span = fdm_pkg::DELAY_DEPTH - 1;
            end
            mix_w = (mix_reg > fdm_pkg::UNITY_GAIN) ? longint'(fdm_pkg::UNITY_GAIN)
                                                    : longint'(mix_reg);
            fb_w = (feedback_reg > fdm_pkg::UNITY_GAIN) ? longint'(fdm_pkg::UNITY_GAIN)
                                                        : longint'(feedback_reg);
            wr = echo_wr_pos[ch];
            rd = (wr >= span) ? wr - span : wr + fdm_pkg::DELAY_DEPTH - span;
            wet = longint'(echo_line[ch][rd]);
            echo_line[ch][wr] = scale_clip(dry * longint'(fdm_pkg::UNITY_GAIN) + wet * fb_w);
            echo_wr_pos[ch] = (wr + 1 >= fdm_pkg::DELAY_DEPTH) ? 0 : wr + 1;
            res.out_sample = scale_clip(dry * (longint'(fdm_pkg::UNITY_GAIN) - mix_w)
                                        + wet * mix_w);
        end
        return res;
    endfunction

    function automatic logic [fdm_pkg::CFG_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return fdm_pkg::UNITY_GAIN;
            2: return fdm_pkg::CFG_W'($urandom_range(65537, 131071));
            default: return fdm_pkg::CFG_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic set_register(input logic [fdm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [fdm_pkg::CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        case (idx)
            fdm_pkg::CFG_DELAY_SAMPLES: delay_reg = value;
            fdm_pkg::CFG_MIX_GAIN: mix_reg = value;
            fdm_pkg::CFG_FEEDBACK_GAIN: feedback_reg = value;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_sample(input logic [fdm_pkg::CHANNEL_W-1:0] lane,
                                input logic signed [fdm_pkg::SAMPLE_W-1:0] value);
        fdm_pkg::in_item_t item;
        item.channel_index = lane;
        item.in_sample = value;
        sample_feed_q = {sample_feed_q, item};
    endtask

    task automatic settle();
        @(negedge aclk);
        while (sample_feed_q.size() != 0 || s_valid || predicted_mix_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted_mix_q = {predicted_mix_q, predict_echo_mix(s_data)};
            end
            if (!s_valid || s_ready) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                    s_valid <= 1'b0;
                end else if (sample_feed_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= sample_feed_q.pop_front();
                    if (feed_burst > 1) begin
                        feed_burst--;
                    end else begin
                        feed_burst = $urandom_range(1, 40);
                        feed_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (squeeze_armed) begin
            squeeze_armed = 1'b0;
            squeeze_left = SQUEEZE_CYCLES;
        end
        if (squeeze_left > 0) begin
            squeeze_left--;
            m_ready <= 1'b0;
        end else begin
            if (drain_left == 0) begin
                drain_mode = drain_mode_t'($urandom_range(0, 2));
                drain_left = $urandom_range(4, 80);
            end else begin
                drain_left--;
            end
            case (drain_mode)
                DRAIN_STEADY: m_ready <= 1'b1;
                DRAIN_CHOPPY: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (predicted_mix_q.size() == 0) begin
                $display("%0t ns: unexpected transaction, actual channel %0d sample %0d",
                         $time, m_data.out_channel, $signed(m_data.out_sample));
                mismatch_count++;
            end else begin
                oldest_mix = predicted_mix_q.pop_front();
                if (m_data.out_channel !== oldest_mix.out_channel) begin
                    $display("%0t ns: out_channel mismatch, expected %0d actual %0d",
                             $time, oldest_mix.out_channel, m_data.out_channel);
                    mismatch_count++;
                end
                if (m_data.out_sample !== oldest_mix.out_sample) begin
                    $display("%0t ns: out_sample mismatch, expected %0d actual %0d",
                             $time, $signed(oldest_mix.out_sample),
                             $signed(m_data.out_sample));
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2ms;
        $display("feedback_delay_dry_wet_mix regression: fail");
        $finish;
    end

    initial begin
        int                                 phase;
        int                                 n;
        logic [fdm_pkg::CFG_W-1:0]          span;
        logic [fdm_pkg::CHANNEL_W-1:0]      lane;
        logic signed [fdm_pkg::SAMPLE_W-1:0] value;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        queue_sample(1'b0, fdm_pkg::SAMPLE_MAX);
        queue_sample(1'b1, fdm_pkg::SAMPLE_MIN);
        queue_sample(1'b0, 24'sd0);
        queue_sample(1'b1, -24'sd1);
        queue_sample(1'b0, 24'sd1);
        queue_sample(1'b1, fdm_pkg::SAMPLE_MAX);
        settle();

        set_register(fdm_pkg::CFG_DELAY_SAMPLES, 17'd1);
        set_register(fdm_pkg::CFG_MIX_GAIN, fdm_pkg::UNITY_GAIN);
        set_register(fdm_pkg::CFG_FEEDBACK_GAIN, fdm_pkg::UNITY_GAIN);
        set_register(CFG_SPARE_INDEX, 17'h1FFFF);
        queue_sample(1'b0, fdm_pkg::SAMPLE_MAX);
        queue_sample(1'b0, fdm_pkg::SAMPLE_MAX);
        queue_sample(1'b0, fdm_pkg::SAMPLE_MAX);
        queue_sample(1'b1, fdm_pkg::SAMPLE_MIN);
        queue_sample(1'b1, fdm_pkg::SAMPLE_MIN);
        queue_sample(1'b0, -24'sd1);
        queue_sample(1'b1, 24'sd1);
        queue_sample(1'b0, fdm_pkg::SAMPLE_MIN);
        settle();

        set_register(fdm_pkg::CFG_DELAY_SAMPLES, 17'd0);
        set_register(fdm_pkg::CFG_MIX_GAIN, 17'h1FFFF);
        set_register(fdm_pkg::CFG_FEEDBACK_GAIN, 17'h1FFFF);
        queue_sample(1'b1, fdm_pkg::SAMPLE_MAX);
        queue_sample(1'b1, fdm_pkg::SAMPLE_MAX);
        queue_sample(1'b0, fdm_pkg::SAMPLE_MIN);
        queue_sample(1'b0, 24'sd12345);
        settle();

        set_register(fdm_pkg::CFG_DELAY_SAMPLES, 17'h1FFFF);
        set_register(fdm_pkg::CFG_MIX_GAIN, 17'd0);
        set_register(fdm_pkg::CFG_FEEDBACK_GAIN, 17'd0);
        queue_sample(1'b0, fdm_pkg::SAMPLE_MAX);
        queue_sample(1'b1, fdm_pkg::SAMPLE_MIN);
        queue_sample(1'b0, -24'sd1);
        queue_sample(1'b1, 24'sd4660);
        settle();

        lane = '0;
        for (phase = 0; phase < 10; phase++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: span = fdm_pkg::CFG_W'($urandom_range(1, 8));
                6, 7: span = fdm_pkg::CFG_W'($urandom_range(9, 400));
                8: span = ($urandom_range(0, 1) == 0) ? 17'd0 : 17'h1FFFF;
                default: span = fdm_pkg::CFG_W'($urandom_range(0, 131071));
            endcase
            set_register(fdm_pkg::CFG_DELAY_SAMPLES, span);
            set_register(fdm_pkg::CFG_MIX_GAIN, pick_gain());
            set_register(fdm_pkg::CFG_FEEDBACK_GAIN, pick_gain());
            if (phase == 2) begin
                set_register(CFG_SPARE_INDEX, fdm_pkg::CFG_W'($urandom()));
            end
            if (phase == 3) begin
                squeeze_armed = 1'b1;
            end
            for (n = 0; n < 130; n++) begin
                if ($urandom_range(0, 1) == 0) begin
                    lane = fdm_pkg::CHANNEL_W'($urandom_range(0, 1));
                end
                case ($urandom_range(0, 7))
                    0: value = fdm_pkg::SAMPLE_MAX;
                    1: value = fdm_pkg::SAMPLE_MIN;
                    2, 3: value = fdm_pkg::SAMPLE_W'($urandom_range(0, 1023) - 512);
                    default: value = fdm_pkg::SAMPLE_W'($urandom());
                endcase
                queue_sample(lane, value);
            end
            settle();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("feedback_delay_dry_wet_mix regression: pass");
        end else begin
            $display("feedback_delay_dry_wet_mix regression: fail");
        end
        $finish;
    end

endmodule
